// ----- hdl/eased_value_interpolator_assert.svh -----
// Assertion macros shared by the RTL of the eased value interpolator.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef EASED_VALUE_INTERPOLATOR_ASSERT_SVH
`define EASED_VALUE_INTERPOLATOR_ASSERT_SVH

// The property must hold in the same cycle as the condition.
`define EVI_ASSERT_SAME(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// The property must hold in the cycle after the condition.
`define EVI_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- hdl/evi_pkg.sv -----
`default_nettype none

package evi_pkg;

    // Default number of fraction bits of the progress value.
    localparam int FRAC_BITS_DEF = 24;

    // Field and register widths.
    localparam int LEVEL_W    = 32;
    localparam int DIFF_W     = LEVEL_W + 1;
    localparam int DUR_W      = 31;
    localparam int CURVE_W    = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;
    localparam int IN_DATA_W  = 3 * LEVEL_W;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DURATION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE    = 1'd1;

    // Curve codes; the remaining codes act as linear.
    localparam logic [CURVE_W-1:0] CURVE_LINEAR   = 3'd0;
    localparam logic [CURVE_W-1:0] CURVE_IN       = 3'd1;
    localparam logic [CURVE_W-1:0] CURVE_OUT      = 3'd2;
    localparam logic [CURVE_W-1:0] CURVE_IN_OUT   = 3'd3;
    localparam logic [CURVE_W-1:0] CURVE_BEZIER   = 3'd4;
    localparam logic [CURVE_W-1:0] CURVE_PARAM    = 3'd5;

endpackage

`default_nettype wire

// ----- hdl/eased_value_interpolator.sv -----
// Eased value interpolator.
// Items enter on the s_ channel (time_now, start_level, end_level) and one
// result per item leaves on the m_ channel (eased_level). The timestamp is
// clamped to the configured duration, divided into a progress fraction,
// shaped by the selected easing curve and used to blend start and end.
// Configuration is written through cfg_we/cfg_index/cfg_data while no item
// is in flight: index 0 is the duration, index 1 the curve code.
// The pipeline has one input stage, a row of FRAC_BITS+1 division cells
// for the progress, two easing multiply stages, a second row of
// FRAC_BITS+1 cells for the parametric curve and two stages for the final
// multiply and add. Throughput is one item per clock unless the
// output stalls. All stages advance together whenever the output register
// is empty or being taken; when the receiver stalls, the whole row holds
// and s_tready drops until m_tready returns.
// Reset clears every valid flag, sets the duration to 1 and the curve to
// linear; no clearing pass is needed.
`default_nettype none

`include "eased_value_interpolator_assert.svh"

module eased_value_interpolator #(
    parameter int FRAC_BITS = evi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [evi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [evi_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata: time_now [31:0], start_level [63:32], end_level [95:64]
    input  wire logic [evi_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: eased_level [31:0]
    output logic      [evi_pkg::LEVEL_W-1:0]       m_tdata
);

    localparam int F   = FRAC_BITS;
    localparam int LW  = evi_pkg::LEVEL_W;
    localparam int DW  = evi_pkg::DIFF_W;
    localparam int RW1 = LW;
    localparam int RW2 = F + 3;
    localparam int PWA = LW + DW;
    localparam int PWB = LW + DW + F + 1;
    localparam int PRW = DW + F + 2;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    logic                          en;
    logic [evi_pkg::DUR_W-1:0]     dur_reg;
    logic [evi_pkg::CURVE_W-1:0]   curve_reg;

    logic signed [LW-1:0] t_in;
    logic signed [LW-1:0] s_in;
    logic signed [LW-1:0] e_in;
    logic [RW1-1:0]       r0_next;
    logic [RW1-1:0]       d0_next;

    logic                 vld0_reg;
    logic [RW1-1:0]       r0_reg;
    logic [RW1-1:0]       d0_reg;
    logic [PWA-1:0]       pay0_reg;

    logic                 vld_d1;
    logic [F:0]           q1;
    logic [PWA-1:0]       pay_d1;

    logic                 vld_e;
    logic [F:0]           sq_e;
    logic [F+2:0]         den_e;
    logic [F:0]           ease_e;
    logic [PWA-1:0]       pay_e;
    logic [RW2-1:0]       r2_in;
    logic [RW2-1:0]       d2_in;

    logic                 vld_d2;
    logic [F:0]           q2;
    logic [PWB-1:0]       pay_d2;
    logic [F:0]           prog;

    logic                 vld3_reg;
    logic signed [PRW-1:0] prod3_reg;
    logic [LW-1:0]        start3_reg;
    logic [LW-1:0]        res_next;

    // The whole row advances when the output register can take a result.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg   <= evi_pkg::DUR_W'(1);
            curve_reg <= evi_pkg::CURVE_LINEAR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                evi_pkg::REG_DURATION: dur_reg   <= cfg_data;
                evi_pkg::REG_CURVE:    curve_reg <= cfg_data[evi_pkg::CURVE_W-1:0];
                default:               dur_reg   <= dur_reg;
            endcase
        end
    end

    // Input stage: clamp the timestamp and form the wide difference.
    // A zero duration divides 1 by 1, which yields exactly one.
    always_comb
    begin
        t_in = s_tdata[LW-1:0];
        s_in = s_tdata[2*LW-1:LW];
        e_in = s_tdata[3*LW-1:2*LW];
        if (dur_reg == '0)
        begin
            r0_next = RW1'(1);
            d0_next = RW1'(1);
        end
        else
        begin
            d0_next = {1'b0, dur_reg};
            if (t_in[LW-1])
            begin
                r0_next = '0;
            end
            else if (t_in[LW-2:0] > dur_reg)
            begin
                r0_next = {1'b0, dur_reg};
            end
            else
            begin
                r0_next = {1'b0, t_in[LW-2:0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_reg   <= r0_next;
            d0_reg   <= d0_next;
            pay0_reg <= {DW'(e_in) - DW'(s_in), s_in};
        end
    end

    // Progress division: (t << FRAC_BITS) / duration.
    evi_div_chain #(
        .N  (F + 1),
        .RW (RW1),
        .PW (PWA)
    ) u_div_prog (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (vld0_reg),
        .r_in    (r0_reg),
        .d_in    (d0_reg),
        .pay_in  (pay0_reg),
        .vld_out (vld_d1),
        .q_out   (q1),
        .pay_out (pay_d1)
    );

    evi_ease #(
        .FRAC_BITS (F),
        .PW        (PWA)
    ) u_ease (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .curve    (curve_reg),
        .vld_in   (vld_d1),
        .p_in     (q1),
        .pay_in   (pay_d1),
        .vld_out  (vld_e),
        .sq_out   (sq_e),
        .den_out  (den_e),
        .ease_out (ease_e),
        .pay_out  (pay_e)
    );

    // Parametric division: (sq << FRAC_BITS) / den. A denominator that is
    // not positive divides 1 by 1 so that the progress becomes one.
    always_comb
    begin
        if (den_e[F+2] || (den_e == '0))
        begin
            r2_in = RW2'(1);
            d2_in = RW2'(1);
        end
        else
        begin
            r2_in = {2'b00, sq_e};
            d2_in = den_e;
        end
    end

    evi_div_chain #(
        .N  (F + 1),
        .RW (RW2),
        .PW (PWB)
    ) u_div_param (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (vld_e),
        .r_in    (r2_in),
        .d_in    (d2_in),
        .pay_in  ({ease_e, pay_e}),
        .vld_out (vld_d2),
        .q_out   (q2),
        .pay_out (pay_d2)
    );

    assign prog = (curve_reg == evi_pkg::CURVE_PARAM) ? q2 : pay_d2[PWB-1:PWA];

    // Scale the difference by the progress.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
            m_tvalid <= 1'b0;
        end
        else if (en)
        begin
            vld3_reg <= vld_d2;
            m_tvalid <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod3_reg  <= PRW'(signed'(pay_d2[PWA-1:LW])) * PRW'(signed'({1'b0, prog}));
            start3_reg <= pay_d2[LW-1:0];
        end
    end

    // Floor shift and add the start level; the result wraps to 32 bits.
    assign res_next = start3_reg + prod3_reg[F+LW-1:F];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata <= res_next;
        end
    end

    `EVI_ASSERT_SAME(a_prog_range, vld_d1, q1 <= ONE, "progress above one")
    `EVI_ASSERT_SAME(a_den_pos, vld_e && (curve_reg == evi_pkg::CURVE_PARAM),
                     (!den_e[F+2]) && (den_e != '0), "parametric denominator not positive")
    `EVI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
                     "stalled result lost")

endmodule

`default_nettype wire

// ----- hdl/evi_div_cell.sv -----
`default_nettype none

// One restoring division step: decides one quotient bit and hands the
// shifted remainder, the divisor and the payload to the next cell.
module evi_div_cell #(
    parameter int RW = 32,
    parameter int QW = 25,
    parameter int PW = 65
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          vld_in,
    input  wire logic [RW-1:0] r_in,
    input  wire logic [RW-1:0] d_in,
    input  wire logic [QW-1:0] q_in,
    input  wire logic [PW-1:0] pay_in,
    output logic               vld_reg,
    output logic      [RW-1:0] r_reg,
    output logic      [RW-1:0] d_reg,
    output logic      [QW-1:0] q_reg,
    output logic      [PW-1:0] pay_reg
);

    logic          ge;
    logic [RW-1:0] rem;
    logic [RW-1:0] r_next;
    logic [QW-1:0] q_next;

    // Compare and subtract, then shift the remainder for the next bit.
    always_comb
    begin
        ge     = (r_in >= d_in);
        rem    = ge ? (r_in - d_in) : r_in;
        r_next = {rem[RW-2:0], 1'b0};
        q_next = {q_in[QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= r_next;
            d_reg   <= d_in;
            q_reg   <= q_next;
            pay_reg <= pay_in;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/evi_div_chain.sv -----
`default_nettype none

// Row of division cells, one quotient bit per cell, MSB first.
module evi_div_chain #(
    parameter int N  = 25,
    parameter int RW = 32,
    parameter int PW = 65
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          vld_in,
    input  wire logic [RW-1:0] r_in,
    input  wire logic [RW-1:0] d_in,
    input  wire logic [PW-1:0] pay_in,
    output logic               vld_out,
    output logic      [N-1:0]  q_out,
    output logic      [PW-1:0] pay_out
);

    logic          vld_c [N+1];
    logic [RW-1:0] r_c   [N+1];
    logic [RW-1:0] d_c   [N+1];
    logic [N-1:0]  q_c   [N+1];
    logic [PW-1:0] pay_c [N+1];

    assign vld_c[0] = vld_in;
    assign r_c[0]   = r_in;
    assign d_c[0]   = d_in;
    assign q_c[0]   = '0;
    assign pay_c[0] = pay_in;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        evi_div_cell #(
            .RW (RW),
            .QW (N),
            .PW (PW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vld_in  (vld_c[i]),
            .r_in    (r_c[i]),
            .d_in    (d_c[i]),
            .q_in    (q_c[i]),
            .pay_in  (pay_c[i]),
            .vld_reg (vld_c[i+1]),
            .r_reg   (r_c[i+1]),
            .d_reg   (d_c[i+1]),
            .q_reg   (q_c[i+1]),
            .pay_reg (pay_c[i+1])
        );
    end

    assign vld_out = vld_c[N];
    assign q_out   = q_c[N];
    assign pay_out = pay_c[N];

endmodule

`default_nettype wire

// ----- hdl/evi_ease.sv -----
`default_nettype none

// Two multiply stages that shape the progress value along the curve and
// prepare the square and denominator for the parametric division.
module evi_ease #(
    parameter int FRAC_BITS = 24,
    parameter int PW        = 65
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic [evi_pkg::CURVE_W-1:0] curve,
    input  wire logic                       vld_in,
    input  wire logic [FRAC_BITS:0]         p_in,
    input  wire logic [PW-1:0]              pay_in,
    output logic                            vld_out,
    output logic      [FRAC_BITS:0]         sq_out,
    output logic      [FRAC_BITS+2:0]       den_out,
    output logic      [FRAC_BITS:0]         ease_out,
    output logic      [PW-1:0]              pay_out
);

    localparam int F  = FRAC_BITS;
    localparam int MW = 2 * F + 3;
    localparam logic [F:0]   ONE    = (F+1)'(1) << F;
    localparam logic [F:0]   HALF   = (F+1)'(1) << (F - 1);
    localparam logic [F+1:0] TWO_1  = (F+2)'(2) << F;
    localparam logic [F+1:0] THREE1 = (F+2)'(3) << F;
    localparam logic [F+2:0] ONE_D  = (F+3)'(1) << F;

    logic [F:0]    op_a;
    logic [F+1:0]  op_b;
    logic          hi_half;

    logic          vld1_reg;
    logic [F:0]    p1_reg;
    logic [MW-1:0] prod1_reg;
    logic [PW-1:0] pay1_reg;

    logic [F:0]          sq1;
    logic [F+1:0]        k1;
    logic signed [F+2:0] dsq;
    logic [F+2:0]        den1;
    logic [MW-1:0]       dbl1;
    logic [F:0]          pre1;

    logic          vld2_reg;
    logic [MW-1:0] prod2_reg;
    logic [F:0]    pre2_reg;
    logic [F:0]    sq2_reg;
    logic [F+2:0]  den2_reg;
    logic [PW-1:0] pay2_reg;

    // Operand selection for the first multiplier.
    always_comb
    begin
        hi_half = (p_in > HALF);
        op_a    = p_in;
        op_b    = {1'b0, p_in};
        unique case (curve)
            evi_pkg::CURVE_OUT:
            begin
                op_b = TWO_1 - {1'b0, p_in};
            end
            evi_pkg::CURVE_IN_OUT:
            begin
                if (hi_half)
                begin
                    op_a = p_in - HALF;
                    op_b = {1'b0, ONE - (p_in - HALF)};
                end
            end
            default:
            begin
                op_b = {1'b0, p_in};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= vld_in;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg    <= p_in;
            prod1_reg <= MW'(op_a) * MW'(op_b);
            pay1_reg  <= pay_in;
        end
    end

    // Second stage: curve values from the first product, the cubic term of
    // the Bezier curve, and the denominator of the parametric curve.
    always_comb
    begin
        sq1  = prod1_reg[2*F:F];
        k1   = THREE1 - {p1_reg, 1'b0};
        dsq  = signed'({2'b00, sq1}) - signed'({2'b00, p1_reg});
        den1 = (F+3)'(dsq <<< 1) + ONE_D;
        dbl1 = prod1_reg >> (F - 1);
        unique case (curve)
            evi_pkg::CURVE_IN:     pre1 = prod1_reg[2*F:F];
            evi_pkg::CURVE_OUT:    pre1 = prod1_reg[2*F:F];
            evi_pkg::CURVE_IN_OUT:
            begin
                if (p1_reg > HALF)
                begin
                    pre1 = dbl1[F:0] + HALF;
                end
                else
                begin
                    pre1 = dbl1[F:0];
                end
            end
            default:               pre1 = p1_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod2_reg <= MW'(sq1) * MW'(k1);
            pre2_reg  <= pre1;
            sq2_reg   <= sq1;
            den2_reg  <= den1;
            pay2_reg  <= pay1_reg;
        end
    end

    assign vld_out  = vld2_reg;
    assign sq_out   = sq2_reg;
    assign den_out  = den2_reg;
    assign ease_out = (curve == evi_pkg::CURVE_BEZIER) ? prod2_reg[2*F:F] : pre2_reg;
    assign pay_out  = pay2_reg;

endmodule

`default_nettype wire

// ----- test/eased_value_interpolator_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels of the interpolator, predicts each eased level and
// compares it with what the block delivers.
module eased_value_interpolator_checker
    import evi_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                     s_tvalid,
    input  wire logic                     s_tready,
    input  wire logic [IN_DATA_W-1:0]     s_tdata,
    input  wire logic                     m_tvalid,
    input  wire logic                     m_tready,
    input  wire logic [LEVEL_W-1:0]       m_tdata,
    output int                            fail_count,
    output int                            pending_count
);
    localparam int FB = FRAC_BITS_DEF;

    logic [DUR_W-1:0]   duration;
    logic [CURVE_W-1:0] curve;
    logic [LEVEL_W-1:0] expected_levels[$];

    // Applies the easing curve to a progress fraction.
    function automatic longint shape_progress(logic [CURVE_W-1:0] c, longint n);
        longint one;
        longint half;
        longint sq;
        longint m;
        longint den;
        one  = longint'(1) << FB;
        half = longint'(1) << (FB - 1);
        case (c)
            CURVE_IN:     return (n * n) >>> FB;
            CURVE_OUT:    return (n * (2 * one - n)) >>> FB;
            CURVE_IN_OUT:
            begin
                if (n <= half)
                    return (2 * (n * n)) >>> FB;
                m = n - half;
                return ((2 * m * (one - m)) >>> FB) + half;
            end
            CURVE_BEZIER:
            begin
                sq = (n * n) >>> FB;
                return (sq * (3 * one - 2 * n)) >>> FB;
            end
            CURVE_PARAM:
            begin
                sq = (n * n) >>> FB;
                den = 2 * (sq - n) + one;
                if (den <= 0)
                    return one;
                return (sq <<< FB) / den;
            end
            default:      return n;
        endcase
    endfunction

    // Computes the eased level for one input item.
    function automatic logic [LEVEL_W-1:0] eased_level_of(logic [IN_DATA_W-1:0] d);
        longint t;
        longint s;
        longint e;
        longint dur;
        longint prog;
        longint prod;
        longint res;
        t   = longint'($signed(d[31:0]));
        s   = longint'($signed(d[63:32]));
        e   = longint'($signed(d[95:64]));
        dur = longint'(duration);
        if (dur == 0)
            prog = longint'(1) << FB;
        else
        begin
            if (t < 0)
                t = 0;
            if (t > dur)
                t = dur;
            prog = shape_progress(curve, (t <<< FB) / dur);
        end
        // The product fits 58 bits, so the arithmetic shift is a floor.
        prod = (e - s) * prog;
        res  = s + (prod >>> FB);
        return res[LEVEL_W-1:0];
    endfunction

    assign pending_count = expected_levels.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration   <= 1;
            curve      <= CURVE_LINEAR;
            fail_count <= 0;
            expected_levels.delete();
        end
        else
        begin
            // Track register writes.
            if (cfg_we)
            begin
                if (cfg_index == REG_DURATION)
                    duration <= cfg_data[DUR_W-1:0];
                else if (cfg_index == REG_CURVE)
                    curve <= cfg_data[CURVE_W-1:0];
            end
            if (s_tvalid && s_tready)
                expected_levels.push_back(eased_level_of(s_tdata));
            // Compare each delivered item with the oldest prediction.
            if (m_tvalid && m_tready)
            begin
                if (expected_levels.size() == 0)
                begin
                    $error("eased_level: unexpected item, actual %0d", $signed(m_tdata));
                    fail_count <= fail_count + 1;
                end
                else if (expected_levels[0] !== m_tdata)
                begin
                    $error("eased_level: expected %0d, actual %0d",
                           $signed(expected_levels[0]), $signed(m_tdata));
                    fail_count <= fail_count + 1;
                    void'(expected_levels.pop_front());
                end
                else
                    void'(expected_levels.pop_front());
            end
        end
    end
endmodule

// ----- test/eased_value_interpolator_test.sv -----
`timescale 1ns / 100ps

// Drives items and register writes into the interpolator and gives the verdict.
module eased_value_interpolator_test;
    import evi_pkg::*;

    localparam int LATENCY = 2 * FRAC_BITS_DEF + 7;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [LEVEL_W-1:0]    m_tdata;
    int                    fail_count;
    int                    pending_count;
    bit                    calm_phase;
    bit                    hold_receiver;

    eased_value_interpolator u_dut (.*);

    eased_value_interpolator_checker u_checker (.*);

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Hard limit on the run.
    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_receiver)
            begin
                m_tready <= 1'b0;
                repeat (200) @(negedge clk);
                hold_receiver = 1'b0;
            end
            else if (!calm_phase && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Writes one register while the block is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Waits until every prediction has been matched.
    task automatic drain();
        while (pending_count != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Offers one item and waits until it is taken; called at a falling edge
    // and returns at the falling edge after acceptance with s_tvalid still set.
    task automatic send_item(logic [31:0] t, logic [31:0] s, logic [31:0] e);
        if (!calm_phase && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {e, s, t};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random level: mixes extremes with arbitrary values.
    function automatic logic [31:0] random_level();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    // Random timestamp around the duration.
    function automatic logic [31:0] random_time(logic [30:0] dur);
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return dur + $urandom_range(0, 3);
            2:       return -$urandom_range(0, 3);
            default: return dur == 0 ? 32'd0 : {1'b0, $urandom} % ({1'b0, dur} + 1);
        endcase
    endfunction

    logic [30:0] dur;
    logic [30:0] dur_set[] = '{31'd1, 31'd0, 31'h7FFF_FFFF, 31'd100, 31'd7,
                               31'd1000000, 31'd3};

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_DURATION;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        calm_phase    = 1'b0;
        hold_receiver = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes at the reset settings, then every curve at mid points.
        @(negedge clk);
        send_item(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(32'd1, 32'd5, 32'hFFFF_FFFF);
        s_tvalid <= 1'b0;
        drain();
        write_reg(REG_DURATION, 31'd16);
        for (int c = 0; c < 8; c++)
        begin
            write_reg(REG_CURVE, CFG_DATA_W'(c));
            @(negedge clk);
            send_item(32'd4, 32'h8000_0000, 32'h7FFF_FFFF);
            send_item(32'd8, 32'h7FFF_FFFF, 32'h8000_0000);
            send_item(32'd13, -32'd1000, 32'd999);
            s_tvalid <= 1'b0;
            drain();
        end
        // Zero duration makes progress exactly one.
        write_reg(REG_DURATION, 31'd0);
        @(negedge clk);
        send_item(32'h1234_5678, 32'd1, 32'd2);
        s_tvalid <= 1'b0;
        drain();

        // Random phases over several settings.
        for (int ph = 0; ph < 24; ph++)
        begin
            dur = ph < dur_set.size() ? dur_set[ph] : 31'($urandom);
            if (ph >= dur_set.size() && $urandom_range(0, 1) == 1)
                dur = 31'($urandom_range(1, 5000));
            write_reg(REG_DURATION, dur);
            write_reg(REG_CURVE, CFG_DATA_W'(ph % 8));
            if (ph == 20)
                calm_phase = 1'b1;
            if (ph == 3)
                hold_receiver = 1'b1;
            @(negedge clk);
            for (int k = 0; k < 72; k++)
                send_item(random_time(dur), random_level(), random_level());
            s_tvalid <= 1'b0;
            // Pause until every result is back.
            drain();
        end

        while (pending_count != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
